[src/rgbhsv_pkg.sv]
// rgbhsv_pkg: request types and fixed widths for the RGB to HSV pixel converter.
// No dependencies; imported by every module of the block.
package rgbhsv_pkg;

  localparam int unsigned CompW = 8;
  localparam int unsigned HueW  = 9;
  localparam int unsigned PctW  = 15;
  localparam int unsigned HueWrap = 360;

  localparam logic [HueW-1:0] HueOffRed   = 9'd360;
  localparam logic [HueW-1:0] HueOffGreen = 9'd120;
  localparam logic [HueW-1:0] HueOffBlue  = 9'd240;

  typedef struct packed {
    logic [CompW-1:0] red_in;
    logic [CompW-1:0] green_in;
    logic [CompW-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [HueW-1:0] hue_deg;
    logic [PctW-1:0] sat_pct;
    logic [PctW-1:0] val_pct;
  } hsv_t;

  typedef struct packed {
    logic valid;
    logic grey;
    logic black;
  } stage_ctl_t;

endpackage

[src/rgb_to_hsv_pixel.sv]
// rgb_to_hsv_pixel: top level of the RGB to HSV pixel converter.
// Uses rgbhsv_pkg and rgbhsv_div.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o with an RGB pixel of 8-bit components in in_req_i.
//   Output channel: out_valid_o / out_stall_i with hue, saturation, value in out_req_o.
//   A request moves when valid is high and stall is low at a rising edge.
//   Throughput: one pixel per cycle while out_stall_i does not freeze the pipeline.
//   The latency is set by the hue and saturation dividers, one quotient bit per
//   stage; value uses a reciprocal multiply and a matching delay line.
//   Stall: when the output holds a request and out_stall_i is high the whole
//   pipeline freezes and in_stall_o is raised; nothing is lost or repeated.
//   Reset: rst_ni clears all valid bits; the block accepts a pixel right after.
//   Saturation and value carry FRAC_BITS fraction bits, truncated to 15 bits.
module rgb_to_hsv_pixel
  import rgbhsv_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  pixel_t in_req_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output hsv_t   out_req_o
);

  localparam int unsigned SW  = 7 + FRAC_BITS;
  localparam int unsigned LAT = (SW > HueW) ? SW : HueW;
  localparam int unsigned NW  = CompW + LAT;
  localparam int unsigned VNW = CompW + SW;
  localparam int unsigned PW  = 2 * VNW + 1;
  localparam logic [SW-1:0] Scale = SW'(100) << FRAC_BITS;
  localparam longint unsigned ValRecip = ((64'd1 << (VNW + 8)) + 64'd254) / 64'd255;

  logic en;
  logic out_valid_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // stage 1: capture
  logic   v1_q;
  pixel_t p1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= in_req_i;
    end
  end

  // stage 2: max, min, sector
  logic [CompW-1:0]   mx_d, mn_d;
  logic signed [8:0]  diff_d;
  logic [HueW-1:0]    off_d;
  logic [CompW-1:0]   r1, g1, b1;

  always_comb begin
    r1 = p1_q.red_in;
    g1 = p1_q.green_in;
    b1 = p1_q.blue_in;
    priority if (r1 >= g1 && r1 >= b1) begin
      mx_d   = r1;
      off_d  = HueOffRed;
      diff_d = $signed({1'b0, g1}) - $signed({1'b0, b1});
    end else if (g1 >= b1) begin
      mx_d   = g1;
      off_d  = HueOffGreen;
      diff_d = $signed({1'b0, b1}) - $signed({1'b0, r1});
    end else begin
      mx_d   = b1;
      off_d  = HueOffBlue;
      diff_d = $signed({1'b0, r1}) - $signed({1'b0, g1});
    end
    priority if (r1 <= g1 && r1 <= b1) begin
      mn_d = r1;
    end else if (g1 <= b1) begin
      mn_d = g1;
    end else begin
      mn_d = b1;
    end
  end

  logic                v2_q;
  logic [CompW-1:0]    mx2_q, d2_q;
  logic signed [8:0]   diff2_q;
  logic [HueW-1:0]     off2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx2_q   <= mx_d;
      d2_q    <= mx_d - mn_d;
      diff2_q <= diff_d;
      off2_q  <= off_d;
    end
  end

  // stage 3: numerators
  logic [17:0]        offd;
  logic signed [18:0] hnum;
  logic [CompW+SW-1:0] sat_num, val_num;
  stage_ctl_t         ctl3_d;

  always_comb begin
    offd    = 18'(d2_q) * 18'(off2_q);
    hnum    = 19'(diff2_q) * 19'sd60 + $signed({1'b0, offd});
    sat_num = (CompW+SW)'(d2_q) * (CompW+SW)'(Scale);
    val_num = (CompW+SW)'(mx2_q) * (CompW+SW)'(Scale);
    ctl3_d.valid = v2_q;
    ctl3_d.grey  = (d2_q == '0);
    ctl3_d.black = (mx2_q == '0);
  end

  stage_ctl_t       ctl3_q;
  logic [NW-1:0]    hnum3_q, snum3_q;
  logic [VNW-1:0]   vnum3_q;
  logic [CompW-1:0] d3_q, mx3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
    end else if (en) begin
      ctl3_q <= ctl3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hnum3_q <= NW'(hnum[16:0]);
      snum3_q <= NW'(sat_num);
      vnum3_q <= val_num;
      d3_q    <= d2_q;
      mx3_q   <= mx2_q;
    end
  end

  // dividers
  logic [LAT-1:0] hq, sq;

  rgbhsv_div #(.DW(CompW), .QW(LAT)) u_div_hue (
    .clk_i, .en_i(en), .num_i(hnum3_q), .div_i(d3_q), .quo_o(hq)
  );
  rgbhsv_div #(.DW(CompW), .QW(LAT)) u_div_sat (
    .clk_i, .en_i(en), .num_i(snum3_q), .div_i(mx3_q), .quo_o(sq)
  );

  // value: floor(x / 255) by reciprocal multiply, then delayed to match the dividers
  logic [PW-1:0] vprod;
  logic [SW-1:0] vq_q [LAT+1];

  assign vprod = PW'(vnum3_q) * PW'(ValRecip);

  always_ff @(posedge clk_i) begin
    if (en) begin
      vq_q[0] <= vprod[VNW+8 +: SW];
      for (int i = 1; i <= LAT; i++) begin
        vq_q[i] <= vq_q[i-1];
      end
    end
  end

  stage_ctl_t ctl_q [LAT+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LAT; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (en) begin
      ctl_q[0] <= ctl3_q;
      for (int i = 1; i <= LAT; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  // output stage
  logic [HueW-1:0]     hq9;
  hsv_t                res_d;
  logic [LAT+PctW-1:0] sx, vx;
  hsv_t                out_q;

  always_comb begin
    hq9 = hq[HueW-1:0];
    sx  = (LAT+PctW)'(sq);
    vx  = (LAT+PctW)'(vq_q[LAT]);
    if (ctl_q[LAT].grey) begin
      res_d.hue_deg = '0;
    end else if (hq9 >= HueW'(HueWrap)) begin
      res_d.hue_deg = hq9 - HueW'(HueWrap);
    end else begin
      res_d.hue_deg = hq9;
    end
    res_d.sat_pct = ctl_q[LAT].black ? '0 : sx[PctW-1:0];
    res_d.val_pct = vx[PctW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl_q[LAT].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

[src/rgbhsv_div.sv]
// rgbhsv_div: pipelined restoring divider, one quotient bit per stage.
// Uses rgbhsv_pkg; requires num_i < div_i * 2**QW.
module rgbhsv_div
  import rgbhsv_pkg::*;
#(
  parameter int unsigned DW = 8,
  parameter int unsigned QW = 9
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DW+QW-1:0] num_i,
  input  logic [DW-1:0]    div_i,
  output logic [QW-1:0]    quo_o
);

  logic [DW-1:0] rem_q [QW+1];
  logic [QW-1:0] lq_q  [QW+1];
  logic [DW-1:0] dv_q  [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i[DW+QW-1:QW];
      lq_q[0]  <= num_i[QW-1:0];
      dv_q[0]  <= div_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_d;
    logic [QW-1:0] lq_d;

    always_comb begin
      trial = {rem_q[k], lq_q[k][QW-1]};
      ge    = trial >= {1'b0, dv_q[k]};
      diff  = trial - {1'b0, dv_q[k]};
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      lq_d  = {lq_q[k][QW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= rem_d;
        lq_q[k+1]  <= lq_d;
        dv_q[k+1]  <= dv_q[k];
      end
    end
  end

  assign quo_o = lq_q[QW];

endmodule

[src/rgbhsv_chk.sv]
// rgbhsv_chk: port-level checks for rgb_to_hsv_pixel, bound to the top level.
// Uses rgbhsv_pkg.
module rgbhsv_chk
  import rgbhsv_pkg::*;
(
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_valid_i,
  input logic   in_stall_o,
  input pixel_t in_req_i,
  input logic   out_valid_o,
  input logic   out_stall_i,
  input hsv_t   out_req_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_req_o))
    else $error("output request changed while stalled");

  a_in_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_req_i))
    else $error("input request changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_req_o.hue_deg < HueW'(HueWrap))
    else $error("hue out of range");

endmodule

bind rgb_to_hsv_pixel rgbhsv_chk u_chk (.*);
